### rtl/uer_pkg.sv
`default_nettype none

package uer_pkg;

  localparam int TIMEOUT_W = 16;
  localparam int TRIGGER_W = 8;
  localparam int DIST_W    = 11;
  localparam int CFG_W     = 16;
  localparam int REM_W     = 6;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd29952;
  localparam logic [TRIGGER_W-1:0] TRIGGER_RESET = 8'd20;

  localparam logic [REM_W-1:0] DIST_BIAS = 6'd29;
  localparam logic [REM_W-1:0] DIST_LAST = 6'd57;

  typedef enum logic {
    REG_TIMEOUT = 1'b0,
    REG_TRIGGER = 1'b1
  } reg_index_t;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_QUIET = 5'b00010,
    PH_TRIG  = 5'b00100,
    PH_RISE  = 5'b01000,
    PH_MEAS  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic start_req;
    logic echo_level;
  } in_t;

  typedef struct packed {
    logic              trigger_level;
    logic              done_res;
    logic              timed_out;
    logic [DIST_W-1:0] distance_cm;
  } out_t;

endpackage

`default_nettype wire

### rtl/uer_core.sv
`default_nettype none

module uer_core #(
  parameter int COUNTER_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           step,
  input  wire uer_pkg::in_t                   item,
  input  wire logic [uer_pkg::TIMEOUT_W-1:0]  timeout_ticks,
  input  wire logic [uer_pkg::TRIGGER_W-1:0]  trigger_ticks,
  output uer_pkg::out_t                       result
);
  import uer_pkg::*;

  localparam int CW = (COUNTER_BITS > TIMEOUT_W) ? COUNTER_BITS : TIMEOUT_W;

  phase_t                  phase;
  phase_t                  phase_next;
  logic [COUNTER_BITS-1:0] tick_count;
  logic [COUNTER_BITS-1:0] tick_count_next;
  logic [COUNTER_BITS-1:0] count_inc;
  logic [DIST_W-1:0]       quot;
  logic [DIST_W-1:0]       quot_next;
  logic [REM_W-1:0]        rem;
  logic [REM_W-1:0]        rem_next;
  logic                    expired;
  logic                    trig_end;
  logic                    fail;

  assign count_inc = tick_count + 1'b1;
  assign expired   = (CW'(tick_count) >= CW'(timeout_ticks)) || (&tick_count);
  assign trig_end  = CW'(count_inc) >= CW'(trigger_ticks);

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    quot_next       = quot;
    rem_next        = rem;
    fail            = 1'b0;
    result          = '0;
    unique case (phase)
      PH_IDLE: begin
        if (item.start_req) begin
          phase_next      = PH_QUIET;
          tick_count_next = '0;
        end
      end
      PH_QUIET: begin
        if (!item.echo_level) begin
          phase_next      = PH_TRIG;
          tick_count_next = '0;
        end else if (expired) begin
          fail = 1'b1;
        end else begin
          tick_count_next = count_inc;
        end
      end
      PH_TRIG: begin
        result.trigger_level = 1'b1;
        if (trig_end) begin
          phase_next      = PH_RISE;
          tick_count_next = '0;
        end else begin
          tick_count_next = count_inc;
        end
      end
      PH_RISE: begin
        if (item.echo_level) begin
          phase_next      = PH_MEAS;
          tick_count_next = '0;
          quot_next       = '0;
          rem_next        = DIST_BIAS;
        end else if (expired) begin
          fail = 1'b1;
        end else begin
          tick_count_next = count_inc;
        end
      end
      PH_MEAS: begin
        if (!item.echo_level) begin
          result.done_res    = 1'b1;
          result.distance_cm = quot;
          phase_next         = PH_IDLE;
          tick_count_next    = '0;
        end else if (expired) begin
          fail = 1'b1;
        end else begin
          tick_count_next = count_inc;
          if (rem == DIST_LAST) begin
            rem_next  = '0;
            quot_next = quot + 1'b1;
          end else begin
            rem_next = rem + 1'b1;
          end
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = '0;
      end
    endcase
    if (fail) begin
      result.done_res    = 1'b1;
      result.timed_out   = 1'b1;
      result.distance_cm = '0;
      phase_next         = PH_IDLE;
      tick_count_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
    end else if (step) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      quot <= quot_next;
      rem  <= rem_next;
    end
  end

  a_meas_from_rise: assert property (@(posedge clk) disable iff (rst)
    (step && phase == PH_MEAS) |-> $past(phase == PH_RISE || phase == PH_MEAS))
    else $error("measuring entered from wrong phase");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (step && phase == PH_IDLE && item.start_req) |=> (phase == PH_QUIET))
    else $error("start not taken while idle");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_MEAS) |-> (rem <= DIST_LAST))
    else $error("remainder out of range");

endmodule

`default_nettype wire

### rtl/ultrasonic_echo_ranger.sv
// Ultrasonic time-of-flight ranger.
// Input channel (in_valid/in_ready/in_data): one transaction per microsecond
// tick, carrying a start request and the sampled echo pin level.
// Output channel (out_valid/out_ready/out_data): exactly one transaction per
// input transaction, carrying the trigger pin level, a done pulse, the
// timed-out flag and the distance in centimetres.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 timeout
// ticks, 1 trigger ticks); write only while no transaction is in flight.
// Each result is registered into the result register, or into the skid register.
// Throughput: one transaction per cycle while in_ready is high; the phase step
// and the running distance quotient (kept by a remainder counter) finish in that cycle.
// A two-entry output stage (result register plus skid register) lets one
// more input transaction in while a result is stalled; in_ready drops only
// when both entries hold data.
// Reset: synchronous; phase returns to idle, the counter clears, both
// output entries empty, the registers take their reset values.
`default_nettype none

module ultrasonic_echo_ranger #(
  parameter int COUNTER_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire uer_pkg::in_t                in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output uer_pkg::out_t                    out_data,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [uer_pkg::CFG_W-1:0]   cfg_data
);
  import uer_pkg::*;

  logic [TIMEOUT_W-1:0] timeout_ticks;
  logic [TRIGGER_W-1:0] trigger_ticks;
  logic                 accept;
  logic                 drain;
  logic                 skid_valid;
  out_t                 skid_data;
  out_t                 result;

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;
  assign drain    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      trigger_ticks <= TRIGGER_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_TIMEOUT: timeout_ticks <= cfg_data[TIMEOUT_W-1:0];
        REG_TRIGGER: trigger_ticks <= cfg_data[TRIGGER_W-1:0];
        default: ;
      endcase
    end
  end

  uer_core #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (accept),
    .item          (in_data),
    .timeout_ticks (timeout_ticks),
    .trigger_ticks (trigger_ticks),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= result;
      end
    end else if (accept) begin
      skid_data <= result;
    end
  end

  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty result register");

  a_tmo_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.timed_out) |-> (out_data.done_res && out_data.distance_cm == '0))
    else $error("timed-out result without done");

  a_dist_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.distance_cm != '0) |-> (out_data.done_res && !out_data.timed_out))
    else $error("distance outside a finished measurement");

  a_stall_fill: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && accept) |=> skid_valid)
    else $error("stalled transaction not captured");

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import uer_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int ROUND_TICKS = 29;
  localparam int TICKS_PER_CM = 58;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_TIMEOUT;
  logic [CFG_W-1:0] cfg_data = '0;

  ultrasonic_echo_ranger dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  phase_t ph = PH_IDLE;
  logic [15:0] tick_cnt = '0;
  logic [TIMEOUT_W-1:0] timeout_reg = TIMEOUT_RESET;
  logic [TRIGGER_W-1:0] trigger_reg = TRIGGER_RESET;

  out_t readings_due[$];
  out_t reading_want;
  int unsigned mismatches = 0;
  int unsigned ticks_sent = 0;
  int unsigned cycle_cnt = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit wait_lapsed();
    if (tick_cnt >= timeout_reg || tick_cnt == 16'hFFFF) return 1'b1;
    tick_cnt = tick_cnt + 16'd1;
    return 1'b0;
  endfunction

  function automatic out_t range_tick(input in_t t);
    out_t r;
    bit lapsed;
    r = '0;
    lapsed = 1'b0;
    case (ph)
      PH_IDLE: begin
        if (t.start_req) begin
          ph = PH_QUIET;
          tick_cnt = '0;
        end
      end
      PH_QUIET: begin
        if (!t.echo_level) begin
          ph = PH_TRIG;
          tick_cnt = '0;
        end else begin
          lapsed = wait_lapsed();
        end
      end
      PH_TRIG: begin
        r.trigger_level = 1'b1;
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt >= {8'd0, trigger_reg}) begin
          ph = PH_RISE;
          tick_cnt = '0;
        end
      end
      PH_RISE: begin
        if (t.echo_level) begin
          ph = PH_MEAS;
          tick_cnt = '0;
        end else begin
          lapsed = wait_lapsed();
        end
      end
      PH_MEAS: begin
        if (!t.echo_level) begin
          r.done_res = 1'b1;
          r.distance_cm = DIST_W'((int'(tick_cnt) + ROUND_TICKS) / TICKS_PER_CM);
          ph = PH_IDLE;
          tick_cnt = '0;
        end else begin
          lapsed = wait_lapsed();
        end
      end
      default: begin
        ph = PH_IDLE;
        tick_cnt = '0;
      end
    endcase
    if (lapsed) begin
      r.done_res = 1'b1;
      r.timed_out = 1'b1;
      r.distance_cm = '0;
      ph = PH_IDLE;
      tick_cnt = '0;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d readings outstanding", $time, readings_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (readings_due.size() == 0) begin
        $display("%0t: unexpected transaction, expected none actual %h", $time, out_data);
        mismatches++;
      end else begin
        reading_want = readings_due.pop_front();
        check_field("trigger_level", reading_want.trigger_level, out_data.trigger_level);
        check_field("done_res", reading_want.done_res, out_data.done_res);
        check_field("timed_out", reading_want.timed_out, out_data.timed_out);
        check_field("distance_cm", reading_want.distance_cm, out_data.distance_cm);
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_tick(input in_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
    readings_due.push_back(range_tick(t));
    ticks_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (readings_due.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [15:0] tmo, input logic [15:0] trg_raw);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_TIMEOUT;
    cfg_data <= tmo;
    @(posedge clk);
    timeout_reg = tmo;
    cfg_index <= REG_TRIGGER;
    cfg_data <= trg_raw;
    @(posedge clk);
    trigger_reg = trg_raw[TRIGGER_W-1:0];
    cfg_we <= 1'b0;
  endtask

  task automatic idle_ticks(input int n);
    in_t t;
    repeat (n) begin
      t.start_req = 1'b0;
      t.echo_level = 1'($urandom_range(1));
      send_tick(t);
    end
  endtask

  // steer the echo from the predicted phase so each measurement runs to its end
  task automatic measure(input int q_len, input int r_len, input int e_len,
                         input int noise_pct);
    in_t t;
    int nq;
    int nr;
    int ne;
    nq = 0;
    nr = 0;
    ne = 0;
    t.start_req = 1'b1;
    t.echo_level = 1'($urandom_range(1));
    send_tick(t);
    while (ph != PH_IDLE) begin
      t.start_req = 1'($urandom_range(1));
      case (ph)
        PH_QUIET: begin
          t.echo_level = (nq < q_len);
          nq++;
        end
        PH_RISE: begin
          t.echo_level = (nr >= r_len);
          nr++;
        end
        PH_MEAS: begin
          t.echo_level = (ne < e_len);
          ne++;
        end
        default: t.echo_level = 1'($urandom_range(1));
      endcase
      if ($urandom_range(99) < noise_pct) t.echo_level = ~t.echo_level;
      send_tick(t);
    end
  endtask

  task automatic test_reset_settings();
    measure(2, 4, 116, 0);
    measure(0, 0, 0, 0);
    idle_ticks(3);
  endtask

  task automatic test_zero_settings();
    reconfigure(16'd0, 16'hA500);
    measure(1, 0, 0, 0);
    measure(0, 1, 0, 0);
    measure(0, 0, 1, 0);
    measure(0, 0, 0, 0);
  endtask

  task automatic test_timeout_edges();
    reconfigure(16'd5, 16'd1);
    measure(5, 0, 0, 0);
    measure(6, 0, 0, 0);
    measure(0, 5, 0, 0);
    measure(0, 6, 0, 0);
    measure(0, 0, 5, 0);
    measure(0, 0, 6, 0);
  endtask

  task automatic test_rounding();
    reconfigure(16'd200, 16'd2);
    measure(0, 1, 28, 0);
    measure(0, 1, 29, 0);
    measure(0, 1, 86, 0);
    measure(0, 1, 87, 0);
    measure(1, 0, 144, 0);
    measure(1, 0, 145, 0);
  endtask

  // longest trigger pulse under the widest timeout
  task automatic test_long_trigger();
    reconfigure(16'hFFFF, 16'd255);
    measure(1, 2, 30, 0);
  endtask

  task automatic test_random(input int s_pct, input int r_pct, input int n);
    int unsigned stop_at;
    logic [15:0] tmo;
    logic [15:0] trg_raw;
    int e_len;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    stop_at = ticks_sent + n;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(15) == 0) begin
        case ($urandom_range(5))
          0: tmo = 16'd0;
          1: tmo = 16'($urandom_range(16, 1));
          2: tmo = 16'($urandom_range(400, 17));
          3: tmo = TIMEOUT_RESET;
          4: tmo = 16'hFFFF;
          default: tmo = 16'($urandom_range(60, 1));
        endcase
        trg_raw = 16'($urandom);
        case ($urandom_range(7))
          0: trg_raw[7:0] = 8'd0;
          1: trg_raw[7:0] = 8'd255;
          default: trg_raw[7:0] = 8'($urandom_range(6, 1));
        endcase
        reconfigure(tmo, trg_raw);
      end
      if ($urandom_range(9) < 8) begin
        case ($urandom_range(19))
          0: e_len = int'($urandom_range(600));
          1, 2, 3, 4: e_len = int'(timeout_reg) + int'($urandom_range(2)) - 1;
          default: e_len = int'($urandom_range(180));
        endcase
        if (e_len > 600) e_len = int'($urandom_range(600));
        measure($urandom_range(4), $urandom_range(12), e_len, $urandom_range(1) * 3);
      end else begin
        in_t t;
        repeat ($urandom_range(8, 1)) begin
          t = in_t'(2'($urandom_range(3)));
          send_tick(t);
        end
      end
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_settings();
    test_zero_settings();
    test_timeout_edges();
    test_rounding();
    test_long_trigger();
    test_random(17, 78, 150);
    test_random(78, 17, 150);
    test_random(0, 0, 120);
    repeat (4) @(posedge clk);
    if (mismatches == 0 && readings_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
